// ===== rtl/iost_pkg.sv =====
// ----------------------------------------------------------------------------
// Idle output shutdown timer package
// Commands, register indexes, shared types and the countdown constants.
// ----------------------------------------------------------------------------
package iost_pkg;

  typedef enum logic [2:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_OUT_ON  = 3'd2,
    CMD_OUT_OFF = 3'd3,
    CMD_RESTORE = 3'd4
  } cmd_e;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_CURRENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_CURRENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIP_IDLE    = 3'd3;

  localparam logic signed [15:0] RST_LOAD_CURRENT = -16'sd50;
  localparam logic [14:0]        RST_IDLE_CURRENT = 15'd50;
  localparam logic [31:0]        RST_OUT_TIMEOUT  = 32'd60000;
  localparam logic [31:0]        RST_SHIP_IDLE    = 32'd3600000;

  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [15:0] NOT_COUNTING = 16'hFFFF;
  localparam logic [15:0] REM_CLIP     = 16'd65534;
  // remaining ms above this rounds up past the clip value
  localparam logic [31:0] DIFF_CLIP    = 32'd65534000;

  // ceil-divide by 1000: (x + 999) >> 3, then * ceil(2^30 / 125) >> 30
  localparam int unsigned X_W         = 26;
  localparam logic [X_W-1:0] ROUND_UP = 26'd999;
  localparam logic [23:0] RECIP       = 24'd8589935;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned PROD_W      = 47;

  typedef enum logic [1:0] {
    SEL_DIV  = 2'd0,
    SEL_NONE = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_CLIP = 2'd3
  } rem_sel_e;

  typedef struct packed {
    logic signed [15:0] load_current_ma;
    logic [14:0]        idle_current_ma;
    logic [31:0]        output_idle_timeout_ms;
    logic [31:0]        ship_idle_ms;
  } cfg_t;

  typedef struct packed {
    logic output_off;
    logic auto_shutdown;
    logic ship_request;
    logic clear_manual_disable;
    logic not_counting;
  } flags_t;

  function automatic logic is_idle(input logic signed [15:0] cur,
                                   input logic [14:0] lim);
    logic signed [16:0] ext;
    logic [16:0]        mag;
    ext = {cur[15], cur};
    mag = ext[16] ? 17'(-ext) : 17'(ext);
    return mag <= {2'b00, lim};
  endfunction

endpackage

// ===== rtl/iost_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Four thresholds written through an indexed write channel.
// ----------------------------------------------------------------------------
module iost_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [iost_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output iost_pkg::cfg_t                cfg_o
);
  import iost_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_current_ma        <= RST_LOAD_CURRENT;
      cfg_q.idle_current_ma        <= RST_IDLE_CURRENT;
      cfg_q.output_idle_timeout_ms <= RST_OUT_TIMEOUT;
      cfg_q.ship_idle_ms           <= RST_SHIP_IDLE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOAD_CURRENT: cfg_q.load_current_ma        <= signed'(cfg_data_i[15:0]);
        REG_IDLE_CURRENT: cfg_q.idle_current_ma        <= cfg_data_i[14:0];
        REG_OUT_TIMEOUT:  cfg_q.output_idle_timeout_ms <= cfg_data_i;
        REG_SHIP_IDLE:    cfg_q.ship_idle_ms           <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/iost_state.sv =====
// ----------------------------------------------------------------------------
// Timer state update
// Input register, idle state update per command and snapshot register.
// ----------------------------------------------------------------------------
module iost_state #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iost_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             command_i,
  input  logic signed [15:0]     current_ma_i,
  input  logic                   manual_disabled_i,
  input  logic                   latched_off_i,
  input  logic [22:0]            restore_seconds_i,
  output logic                   snap_valid_o,
  input  logic                   snap_ready_i,
  output iost_pkg::flags_t       snap_flags_o,
  output logic [TIME_WIDTH-1:0]  snap_since_o,
  output logic [TIME_WIDTH-1:0]  snap_carry_o
);
  import iost_pkg::*;

  localparam int unsigned CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int unsigned XW = (TIME_WIDTH > 33) ? TIME_WIDTH : 33;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  // input beat
  logic                     in_v_q;
  logic [2:0]               cmd_q;
  logic signed [15:0]       cur_q;
  logic                     md_q;
  logic                     lo_q;
  logic [22:0]              rs_q;

  // timer state
  logic [TIME_WIDTH-1:0]    since_q, since_d;
  logic [TIME_WIDTH-1:0]    carry_q, carry_d;
  logic                     started_q, started_d;
  logic                     off_q, off_d;
  logic                     auto_q, auto_d;
  logic                     ship_q, ship_d;
  logic signed [15:0]       last_cur_q, last_cur_d;
  logic [1:0]               last_flags_q, last_flags_d;
  logic                     clr_d;

  // snapshot
  logic                     snap_v_q;
  flags_t                   snap_flags_q;
  logic [TIME_WIDTH-1:0]    snap_since_q;
  logic [TIME_WIDTH-1:0]    snap_carry_q;

  logic                     snap_adv;
  logic                     fire;
  logic [TIME_WIDTH:0]      sum;
  logic [TIME_WIDTH-1:0]    idle_old;
  logic [TIME_WIDTH-1:0]    idle_t;
  logic signed [16:0]       cur_x;
  logic signed [16:0]       load_x;
  logic signed [16:0]       lim_x;
  logic                     activity;
  logic [1:0]               smp_flags;
  logic                     off_mid;
  logic [XW-1:0]            restore_ms;

  assign snap_adv   = !snap_v_q || snap_ready_i;
  assign in_ready_o = !in_v_q || snap_adv;
  assign fire       = in_v_q && snap_adv;

  assign sum      = {1'b0, since_q} + {1'b0, carry_q};
  assign idle_old = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];

  assign cur_x     = {cur_q[15], cur_q};
  assign load_x    = {cfg_i.load_current_ma[15], cfg_i.load_current_ma};
  assign lim_x     = signed'({2'b00, cfg_i.idle_current_ma});
  assign activity  = (cur_x < load_x) || (cur_x > lim_x);
  assign smp_flags = {lo_q, md_q};
  assign off_mid   = (activity && smp_flags == 2'b00) ? 1'b0 : off_q;
  assign idle_t    = activity ? '0 : idle_old;

  assign restore_ms = XW'(rs_q) * XW'(MS_PER_SEC);

  always_comb begin
    since_d      = since_q;
    carry_d      = carry_q;
    started_d    = started_q;
    off_d        = off_q;
    auto_d       = auto_q;
    ship_d       = ship_q;
    last_cur_d   = last_cur_q;
    last_flags_d = last_flags_q;
    clr_d        = 1'b0;
    case (cmd_q)
      CMD_SAMPLE: begin
        started_d = 1'b1;
        if (activity) begin
          since_d = '0;
          carry_d = '0;
        end
        off_d = off_mid;
        if (activity && smp_flags == 2'b00) begin
          auto_d = 1'b0;
        end
        if (is_idle(cur_q, cfg_i.idle_current_ma) && !off_mid &&
            CW'(idle_t) >= CW'(cfg_i.output_idle_timeout_ms)) begin
          off_d  = 1'b1;
          auto_d = 1'b1;
        end
        if (off_d && CW'(idle_t) >= CW'(cfg_i.ship_idle_ms)) begin
          ship_d = 1'b1;
        end
        last_cur_d   = cur_q;
        last_flags_d = smp_flags;
      end
      CMD_TICK: begin
        if (started_q && since_q != TIME_MAX) begin
          since_d = since_q + 1'b1;
        end
      end
      CMD_OUT_ON: begin
        off_d        = 1'b0;
        auto_d       = 1'b0;
        last_flags_d = last_flags_q & 2'b10;
        clr_d        = 1'b1;
        started_d    = 1'b1;
        since_d      = '0;
        carry_d      = '0;
      end
      CMD_OUT_OFF: begin
        off_d     = 1'b1;
        auto_d    = 1'b0;
        started_d = 1'b1;
        since_d   = '0;
        carry_d   = '0;
      end
      CMD_RESTORE: begin
        carry_d = (restore_ms > XW'(TIME_MAX)) ? TIME_MAX : restore_ms[TIME_WIDTH-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      snap_v_q <= 1'b0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (snap_adv)   snap_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      cur_q <= current_ma_i;
      md_q  <= manual_disabled_i;
      lo_q  <= latched_off_i;
      rs_q  <= restore_seconds_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q      <= '0;
      carry_q      <= '0;
      started_q    <= 1'b0;
      off_q        <= 1'b0;
      auto_q       <= 1'b0;
      ship_q       <= 1'b0;
      last_cur_q   <= '0;
      last_flags_q <= '0;
    end else if (fire) begin
      since_q      <= since_d;
      carry_q      <= carry_d;
      started_q    <= started_d;
      off_q        <= off_d;
      auto_q       <= auto_d;
      ship_q       <= ship_d;
      last_cur_q   <= last_cur_d;
      last_flags_q <= last_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      snap_flags_q.output_off           <= off_d;
      snap_flags_q.auto_shutdown        <= auto_d;
      snap_flags_q.ship_request         <= ship_d;
      snap_flags_q.clear_manual_disable <= clr_d;
      snap_flags_q.not_counting         <= !is_idle(last_cur_d, cfg_i.idle_current_ma) ||
                                           off_d || last_flags_d != 2'b00 || !started_d;
      snap_since_q <= since_d;
      snap_carry_q <= carry_d;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_flags_o = snap_flags_q;
  assign snap_since_o = snap_since_q;
  assign snap_carry_o = snap_carry_q;

endmodule

// ===== rtl/iost_remain.sv =====
// ----------------------------------------------------------------------------
// Remaining time pipeline
// Idle sum, countdown select, divide by 1000 and the result register.
// ----------------------------------------------------------------------------
module iost_remain #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iost_pkg::cfg_t         cfg_i,
  input  logic                   snap_valid_i,
  output logic                   snap_ready_o,
  input  iost_pkg::flags_t       snap_flags_i,
  input  logic [TIME_WIDTH-1:0]  snap_since_i,
  input  logic [TIME_WIDTH-1:0]  snap_carry_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output iost_pkg::flags_t       out_flags_o,
  output logic [15:0]            out_remaining_o
);
  import iost_pkg::*;

  localparam int unsigned CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  logic                  t_v_q;
  flags_t                t_flags_q;
  logic [TIME_WIDTH-1:0] t_q;

  logic                  c_v_q;
  flags_t                c_flags_q;
  rem_sel_e              c_sel_q, c_sel_d;
  logic [X_W-1:0]        c_x_q;

  logic                  o_v_q;
  flags_t                o_flags_q;
  logic [15:0]           o_rem_q, o_rem_d;

  logic                  o_adv, c_adv, t_adv;
  logic [TIME_WIDTH:0]   sum;
  logic [CW-1:0]         diff_w;
  logic [31:0]           diff;
  logic [22:0]           y;
  logic [PROD_W-1:0]     prod;

  assign o_adv        = !o_v_q || out_ready_i;
  assign c_adv        = !c_v_q || o_adv;
  assign t_adv        = !t_v_q || c_adv;
  assign snap_ready_o = t_adv;

  assign sum = {1'b0, snap_since_i} + {1'b0, snap_carry_i};

  assign diff_w = CW'(cfg_i.output_idle_timeout_ms) - CW'(t_q);
  assign diff   = diff_w[31:0];

  always_comb begin
    if (t_flags_q.not_counting) begin
      c_sel_d = SEL_NONE;
    end else if (CW'(t_q) >= CW'(cfg_i.output_idle_timeout_ms)) begin
      c_sel_d = SEL_ZERO;
    end else if (diff > DIFF_CLIP) begin
      c_sel_d = SEL_CLIP;
    end else begin
      c_sel_d = SEL_DIV;
    end
  end

  assign y    = c_x_q[X_W-1:3];
  assign prod = PROD_W'(y) * PROD_W'(RECIP);

  always_comb begin
    case (c_sel_q)
      SEL_NONE: o_rem_d = NOT_COUNTING;
      SEL_ZERO: o_rem_d = '0;
      SEL_CLIP: o_rem_d = REM_CLIP;
      SEL_DIV:  o_rem_d = prod[RECIP_SHIFT+15:RECIP_SHIFT];
      default:  o_rem_d = NOT_COUNTING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (t_adv) t_v_q <= snap_valid_i;
      if (c_adv) c_v_q <= t_v_q;
      if (o_adv) o_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_adv && snap_valid_i) begin
      t_flags_q <= snap_flags_i;
      t_q       <= sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
    end
    if (c_adv && t_v_q) begin
      c_flags_q <= t_flags_q;
      c_sel_q   <= c_sel_d;
      c_x_q     <= diff[X_W-1:0] + ROUND_UP;
    end
    if (o_adv && c_v_q) begin
      o_flags_q <= c_flags_q;
      o_rem_q   <= o_rem_d;
    end
  end

  assign out_valid_o     = o_v_q;
  assign out_flags_o     = o_flags_q;
  assign out_remaining_o = o_rem_q;

endmodule

// ===== rtl/idle_output_shutdown_timer.sv =====
// A beat passes the input register, the snapshot register, then the sum, select and result registers.
// Throughput: one beat per cycle unless out_ready_i stalls the pipeline; the timer state updates per beat.
// The countdown (sum, select, multiply by reciprocal) is three further stages.
// Reset: timer state and flags clear, thresholds load defaults, no sweep.
// ----------------------------------------------------------------------------
// Idle output shutdown timer
// Tracks pack idle time and raises auto shutdown and ship-mode requests.
// ----------------------------------------------------------------------------
module idle_output_shutdown_timer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iost_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     command_i,
  input  logic signed [15:0]             current_ma_i,
  input  logic                           manual_disabled_i,
  input  logic                           latched_off_i,
  input  logic [22:0]                    restore_seconds_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           output_off_o,
  output logic                           auto_shutdown_o,
  output logic                           ship_request_o,
  output logic [15:0]                    remaining_sec_o,
  output logic                           clear_manual_disable_o
);
  import iost_pkg::*;

  cfg_t                  cfg;
  logic                  snap_valid;
  logic                  snap_ready;
  flags_t                snap_flags;
  logic [TIME_WIDTH-1:0] snap_since;
  logic [TIME_WIDTH-1:0] snap_carry;
  flags_t                out_flags;

  iost_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  iost_state #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_state (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .current_ma_i      (current_ma_i),
    .manual_disabled_i (manual_disabled_i),
    .latched_off_i     (latched_off_i),
    .restore_seconds_i (restore_seconds_i),
    .snap_valid_o      (snap_valid),
    .snap_ready_i      (snap_ready),
    .snap_flags_o      (snap_flags),
    .snap_since_o      (snap_since),
    .snap_carry_o      (snap_carry)
  );

  iost_remain #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_remain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .snap_valid_i    (snap_valid),
    .snap_ready_o    (snap_ready),
    .snap_flags_i    (snap_flags),
    .snap_since_i    (snap_since),
    .snap_carry_i    (snap_carry),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_flags_o     (out_flags),
    .out_remaining_o (remaining_sec_o)
  );

  assign output_off_o           = out_flags.output_off;
  assign auto_shutdown_o        = out_flags.auto_shutdown;
  assign ship_request_o         = out_flags.ship_request;
  assign clear_manual_disable_o = out_flags.clear_manual_disable;

endmodule
